// File: rtl/mtb_pkg.sv
// ----------------------------------------------------------------------------
// mtb_pkg
// Shared types and constants of the single-touch event decoder.
// ----------------------------------------------------------------------------
package mtb_pkg;

	// Event types and codes
	localparam logic [15:0] EvtSyn       = 16'd0;
	localparam logic [15:0] EvtKey       = 16'd1;
	localparam logic [15:0] EvtAbs       = 16'd3;
	localparam logic [15:0] SyncReport   = 16'd0;
	localparam logic [15:0] SyncDropped  = 16'd3;
	localparam logic [15:0] AxisSlot     = 16'h002F;
	localparam logic [15:0] AxisPosX     = 16'h0035;
	localparam logic [15:0] AxisPosY     = 16'h0036;
	localparam logic [15:0] AxisTrackId  = 16'h0039;

	// Key codes
	localparam logic [15:0] KeyPower     = 16'd116;
	localparam logic [15:0] KeyPagePrev  = 16'd104;
	localparam logic [15:0] KeyPageNext  = 16'd109;
	localparam logic [15:0] KeyHome      = 16'd102;
	localparam logic [15:0] KeyMenu      = 16'd139;
	localparam logic [15:0] KeyBack      = 16'd158;

	localparam logic [2:0] KeyIdPower    = 3'd0;
	localparam logic [2:0] KeyIdPagePrev = 3'd1;
	localparam logic [2:0] KeyIdPageNext = 3'd2;
	localparam logic [2:0] KeyIdHome     = 3'd3;
	localparam logic [2:0] KeyIdMenu     = 3'd4;
	localparam logic [2:0] KeyIdBack     = 3'd5;

	localparam logic signed [31:0] KeyRepeat = 32'sd2;

	// Result kinds
	localparam logic [2:0] KindKey    = 3'd0;
	localparam logic [2:0] KindDown   = 3'd1;
	localparam logic [2:0] KindMove   = 3'd2;
	localparam logic [2:0] KindUp     = 3'd3;
	localparam logic [2:0] KindCancel = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] RegTouch   = 3'd0;
	localparam logic [2:0] RegXMin    = 3'd1;
	localparam logic [2:0] RegXMax    = 3'd2;
	localparam logic [2:0] RegYMin    = 3'd3;
	localparam logic [2:0] RegYMax    = 3'd4;
	localparam logic [2:0] RegWidth   = 3'd5;
	localparam logic [2:0] RegHeight  = 3'd6;
	localparam logic [2:0] RegOrient  = 3'd7;

	// Time conversion: usec / 1000 as a multiply by 2^30/1000 rounded up
	localparam logic [20:0] UsecRecip = 21'd1073742;
	localparam int          UsecShift = 30;
	localparam logic [9:0]  MsPerSec  = 10'd1000;

	// Divider geometry: numerator is a 34-bit offset times a 14-bit size
	localparam int NumW = 48;
	localparam int DenW = 34;

	typedef struct packed {
		logic capture;   // latch the accepted event
		logic apply;     // plan results and update tracking state
		logic div_start; // start scaling one axis
		logic div_axis;  // 0: X, 1: Y
		logic emit_sel;  // 0: first result, 1: second result
	} mtb_cmd_t;

	typedef struct packed {
		logic [1:0] plan_cnt;
		logic       plan_map;
		logic       two;
		logic       div_done;
	} mtb_sts_t;

endpackage

// File: rtl/mtb_div.sv
// ----------------------------------------------------------------------------
// mtb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtb_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mtb_pkg::NumW-1:0] num,
	input  logic [mtb_pkg::DenW-1:0] den,
	output logic                     done,
	output logic [mtb_pkg::NumW-1:0] quo
);
	import mtb_pkg::*;

	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] quo_q;
	logic [DenW-1:0] den_q;
	logic [DenW-1:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DenW:0]   trial;
	logic            fits;

	// Done is raised once all quotient bits have been shifted in.
	assign trial = {rem_q, quo_q[NumW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = busy_q && (cnt_q == CntW'(NumW));
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q && !done) begin
			quo_q <= {quo_q[NumW-2:0], fits};
			rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
		end
	end
endmodule

// File: rtl/mtb_ctrl.sv
// ----------------------------------------------------------------------------
// mtb_ctrl
// Sequencer: takes one event, plans its results, scales both axes if mapped, emits.
// ----------------------------------------------------------------------------
module mtb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  mtb_pkg::mtb_sts_t sts,
	output mtb_pkg::mtb_cmd_t cmd
);
	import mtb_pkg::*;

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StDecode = 3'd1;
	localparam logic [2:0] StXGo    = 3'd2;
	localparam logic [2:0] StXWait  = 3'd3;
	localparam logic [2:0] StYGo    = 3'd4;
	localparam logic [2:0] StYWait  = 3'd5;
	localparam logic [2:0] StEmitA  = 3'd6;
	localparam logic [2:0] StEmitB  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall  = state_q != StIdle;
	assign out_valid = (state_q == StEmitA) || (state_q == StEmitB);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.emit_sel  = state_q == StEmitB;
		unique case (state_q)
			StIdle: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = StDecode;
			end
			StDecode: begin
				cmd.apply = 1'b1;
				if (sts.plan_cnt == 2'd0) state_d = StIdle;
				else if (sts.plan_map) state_d = StXGo;
				else state_d = StEmitA;
			end
			StXGo: begin
				cmd.div_start = 1'b1;
				cmd.div_axis  = 1'b0;
				state_d       = StXWait;
			end
			StXWait: begin
				if (sts.div_done) state_d = StYGo;
			end
			StYGo: begin
				cmd.div_start = 1'b1;
				cmd.div_axis  = 1'b1;
				state_d       = StYWait;
			end
			StYWait: begin
				if (sts.div_done) state_d = StEmitA;
			end
			StEmitA: begin
				if (!out_stall) state_d = sts.two ? StEmitB : StIdle;
			end
			StEmitB: begin
				if (!out_stall) state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/mtb_dp.sv
// ----------------------------------------------------------------------------
// mtb_dp
// Datapath: configuration, contact tracking, coordinate mapping, results.
// ----------------------------------------------------------------------------
module mtb_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [15:0]       ev_type,
	input  logic [15:0]       ev_code,
	input  logic signed [31:0] ev_value,
	input  logic [31:0]       stamp_sec,
	input  logic [19:0]       stamp_usec,
	output logic [2:0]        kind,
	output logic [2:0]        key_id,
	output logic              pressed,
	output logic [12:0]       pos_x,
	output logic [12:0]       pos_y,
	output logic [41:0]       time_ms,
	output logic              last,
	input  mtb_pkg::mtb_cmd_t cmd,
	output mtb_pkg::mtb_sts_t sts
);
	import mtb_pkg::*;

	// Configuration
	logic              touch_q;
	logic signed [31:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic [13:0]       width_q, height_q;
	logic [2:0]        orient_q;

	// Captured event
	logic [15:0]       type_q, code_q;
	logic signed [31:0] value_q;
	logic [41:0]       sec_ms_q;
	logic [10:0]       usec_ms_q;

	// Tracking state
	logic signed [31:0] cur_slot_q, prim_slot_q, raw_x_q, raw_y_q;
	logic              contact_q, down_pend_q, up_pend_q, moved_q, resync_q;

	// Planned results
	logic [2:0]        kind_a_q, kind_b_q, key_id_q;
	logic              pressed_q, two_q;
	logic [12:0]       pos_x_q, pos_y_q;
	logic              axis_q;

	// Event decode
	logic is_dropped, is_report, is_abs, is_key;
	logic [2:0] kidx;
	logic kvalid;
	logic cd_new, first_ok, up_fire, slot_match;
	logic [1:0] plan_cnt;
	logic plan_map;
	logic [2:0] plan_ka, plan_kb;

	assign is_dropped = (type_q == EvtSyn) && (code_q == SyncDropped);
	assign is_report  = (type_q == EvtSyn) && (code_q == SyncReport);
	assign is_abs     = type_q == EvtAbs;
	assign is_key     = type_q == EvtKey;
	assign slot_match = cur_slot_q == prim_slot_q;

	always_comb begin
		kvalid = 1'b1;
		unique case (code_q)
			KeyPower:    kidx = KeyIdPower;
			KeyPagePrev: kidx = KeyIdPagePrev;
			KeyPageNext: kidx = KeyIdPageNext;
			KeyHome:     kidx = KeyIdHome;
			KeyMenu:     kidx = KeyIdMenu;
			KeyBack:     kidx = KeyIdBack;
			default: begin
				kidx   = KeyIdPower;
				kvalid = 1'b0;
			end
		endcase
	end

	// A down on this report makes the contact live before the up is checked.
	assign cd_new   = down_pend_q | contact_q;
	assign first_ok = down_pend_q | (moved_q & contact_q & ~up_pend_q);
	assign up_fire  = up_pend_q & cd_new;

	always_comb begin
		plan_cnt = 2'd0;
		plan_map = 1'b0;
		plan_ka  = KindKey;
		plan_kb  = KindUp;
		if (!touch_q) begin
			plan_cnt = {1'b0, is_key && kvalid && (value_q != KeyRepeat)};
		end else if (is_dropped) begin
			plan_cnt = {1'b0, contact_q};
			plan_map = 1'b1;
			plan_ka  = KindCancel;
		end else if (is_report && !resync_q) begin
			plan_cnt = 2'({1'b0, first_ok}) + 2'({1'b0, up_fire});
			plan_map = 1'b1;
			plan_ka  = !first_ok ? KindUp : (down_pend_q ? KindDown : KindMove);
		end
	end

	// Coordinate mapping for one axis
	logic signed [32:0] xo, yo, mxo, myo, a_off, a_span;
	logic signed [34:0] v, dv;
	logic [13:0] size, lim, cl;
	logic mir, map_axis, zero;
	logic [NumW-1:0] quo;
	logic div_done;

	assign map_axis = cmd.div_start ? cmd.div_axis : axis_q;
	assign xo  = 33'(raw_x_q) - 33'(xmin_q);
	assign yo  = 33'(raw_y_q) - 33'(ymin_q);
	assign mxo = 33'(xmax_q) - 33'(xmin_q);
	assign myo = 33'(ymax_q) - 33'(ymin_q);

	always_comb begin
		if (!map_axis) begin
			a_off  = orient_q[0] ? yo : xo;
			a_span = orient_q[0] ? myo : mxo;
			mir    = orient_q[1];
			size   = width_q;
		end else begin
			a_off  = orient_q[0] ? xo : yo;
			a_span = orient_q[0] ? mxo : myo;
			mir    = orient_q[2];
			size   = height_q;
		end
		v    = mir ? (35'(a_span) - 35'(a_off)) : 35'(a_off);
		dv   = 35'(a_span) + 35'sd1;
		zero = dv[34] || (dv == '0) || (size == '0) || v[34] || (v == '0);
		lim  = size - 14'd1;
		if (|quo[NumW-1:14]) cl = lim;
		else cl = (quo[13:0] > lim) ? lim : quo[13:0];
	end

	mtb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (NumW'(v[33:0]) * NumW'(size)),
		.den    (dv[DenW-1:0]),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_q  <= 1'b1;
			xmin_q   <= '0;
			xmax_q   <= 32'sd4095;
			ymin_q   <= '0;
			ymax_q   <= 32'sd4095;
			width_q  <= 14'd1024;
			height_q <= 14'd768;
			orient_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegTouch:  touch_q  <= cfg_data[0];
				RegXMin:   xmin_q   <= cfg_data;
				RegXMax:   xmax_q   <= cfg_data;
				RegYMin:   ymin_q   <= cfg_data;
				RegYMax:   ymax_q   <= cfg_data;
				RegWidth:  width_q  <= cfg_data[13:0];
				RegHeight: height_q <= cfg_data[13:0];
				RegOrient: orient_q <= cfg_data[2:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_slot_q  <= '0;
			prim_slot_q <= -32'sd1;
			contact_q   <= 1'b0;
			raw_x_q     <= '0;
			raw_y_q     <= '0;
			down_pend_q <= 1'b0;
			up_pend_q   <= 1'b0;
			moved_q     <= 1'b0;
			resync_q    <= 1'b0;
		end else if (cmd.apply && touch_q) begin
			if (is_dropped) begin
				contact_q   <= 1'b0;
				down_pend_q <= 1'b0;
				up_pend_q   <= 1'b0;
				moved_q     <= 1'b0;
				prim_slot_q <= -32'sd1;
				resync_q    <= 1'b1;
			end else if (is_abs && !resync_q) begin
				unique case (code_q)
					AxisSlot: cur_slot_q <= value_q;
					AxisTrackId: begin
						if (!value_q[31]) begin
							if (prim_slot_q[31] && !contact_q) begin
								prim_slot_q <= cur_slot_q;
								down_pend_q <= 1'b1;
							end
						end else if (slot_match) begin
							up_pend_q <= 1'b1;
						end
					end
					AxisPosX: begin
						if (slot_match) begin
							raw_x_q <= value_q;
							moved_q <= 1'b1;
						end
					end
					AxisPosY: begin
						if (slot_match) begin
							raw_y_q <= value_q;
							moved_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end else if (is_report) begin
				if (resync_q) begin
					resync_q <= 1'b0;
				end else begin
					contact_q   <= cd_new & ~up_fire;
					if (up_fire) prim_slot_q <= -32'sd1;
					down_pend_q <= 1'b0;
					up_pend_q   <= 1'b0;
					moved_q     <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q    <= ev_type;
			code_q    <= ev_code;
			value_q   <= ev_value;
			sec_ms_q  <= 42'(stamp_sec) * 42'(MsPerSec);
			usec_ms_q <= 11'((41'(stamp_usec) * 41'(UsecRecip)) >> UsecShift);
		end
		if (cmd.apply) begin
			kind_a_q  <= plan_ka;
			kind_b_q  <= plan_kb;
			two_q     <= plan_cnt == 2'd2;
			key_id_q  <= touch_q ? KeyIdPower : kidx;
			pressed_q <= !touch_q && (value_q != '0);
		end
		if (cmd.div_start) axis_q <= cmd.div_axis;
		if (div_done) begin
			if (!axis_q) pos_x_q <= zero ? '0 : (cl[13] ? 13'h1FFF : cl[12:0]);
			else pos_y_q <= zero ? '0 : (cl[13] ? 13'h1FFF : cl[12:0]);
		end
	end

	assign kind    = cmd.emit_sel ? kind_b_q : kind_a_q;
	assign key_id  = key_id_q;
	assign pressed = pressed_q;
	assign pos_x   = (kind == KindKey) ? '0 : pos_x_q;
	assign pos_y   = (kind == KindKey) ? '0 : pos_y_q;
	assign time_ms = sec_ms_q + 42'(usec_ms_q);
	assign last    = cmd.emit_sel | ~two_q;

	assign sts.plan_cnt = plan_cnt;
	assign sts.plan_map = plan_map;
	assign sts.two      = two_q;
	assign sts.div_done = div_done;
endmodule

// File: rtl/mt_protocol_b_single_touch_decoder_top.sv
// ----------------------------------------------------------------------------
// mt_protocol_b_single_touch_decoder_top
// Input event decoder for key devices and multitouch protocol B panels.
// ----------------------------------------------------------------------------
// One event is taken at a time. An event that yields no result passes through
// the decode state only; a key result also goes through the emit state and
// waits out any output stall. A sync report or dropped sync with results
// scales both axes on one shared restoring divider at one quotient bit per
// cycle (48 quotient bits per axis), before its results are emitted one by one.
// Configuration writes are taken at any time but only while no event
// is in flight do they apply safely.
module mt_protocol_b_single_touch_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        ev_type,
	input  logic [15:0]        ev_code,
	input  logic signed [31:0] ev_value,
	input  logic [31:0]        stamp_sec,
	input  logic [19:0]        stamp_usec,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [2:0]         key_id,
	output logic               pressed,
	output logic [12:0]        pos_x,
	output logic [12:0]        pos_y,
	output logic [41:0]        time_ms,
	output logic               last
);
	import mtb_pkg::*;

	mtb_cmd_t cmd;
	mtb_sts_t sts;

	mtb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mtb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.ev_type    (ev_type),
		.ev_code    (ev_code),
		.ev_value   (ev_value),
		.stamp_sec  (stamp_sec),
		.stamp_usec (stamp_usec),
		.kind       (kind),
		.key_id     (key_id),
		.pressed    (pressed),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.time_ms    (time_ms),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts)
	);
endmodule
